// ===== sv/assert_macros.svh =====
// Assertion macros for the RTL of the load cell reader.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is suspended while reset is asserted (active low reset).
`define LCAR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define LCAR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/lcar_pkg.sv =====
// Package with word types, register codes and the sequencer program of the load cell reader.
package lcar_pkg;

    // Fixed field widths of the channels
    localparam int RAW_W    = 24;
    localparam int WEIGHT_W = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int TARE_W   = 24;
    localparam int DIVIS_W  = 24;
    localparam int HALF_W   = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TARE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIVISOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;

    // Register reset values
    localparam logic [TARE_W-1:0]  TARE_RST  = 24'd100;
    localparam logic [DIVIS_W-1:0] DIVIS_RST = 24'd1000;
    localparam logic [HALF_W-1:0]  HALF_RST  = 8'd1;

    // Channel words
    typedef struct packed {
        logic start_request;
        logic data_pin;
    } t_in_word;

    typedef struct packed {
        logic                clock_pin;
        logic                busy_res;
        logic                done_res;
        logic [RAW_W-1:0]    raw_code;
        logic [WEIGHT_W-1:0] weight;
    } t_res_word;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0] wr_data;
    } t_cfg_word;

    // Sequencer program counter and step addresses
    typedef logic [2:0] t_pc;

    localparam t_pc PC_FETCH    = 3'd0;
    localparam t_pc PC_UPDATE   = 3'd1;
    localparam t_pc PC_DIV_INIT = 3'd2;
    localparam t_pc PC_DIV_STEP = 3'd3;
    localparam t_pc PC_DIV_FIN  = 3'd4;
    localparam t_pc PC_EMIT     = 3'd5;
    localparam t_pc PC_RETURN   = 3'd6;

    // Jump conditions
    typedef enum logic [2:0] {
        COND_NONE,
        COND_ALWAYS,
        COND_NO_IN,
        COND_NOT_FINAL,
        COND_DIV_MORE,
        COND_OUT_BUSY
    } t_cond;

    // One control word
    typedef struct packed {
        logic  in_rdy;
        logic  upd;
        logic  div_init;
        logic  div_step;
        logic  div_fin;
        logic  emit;
        t_cond cond;
        t_pc   target;
    } t_ctrl;

    // Read-only program: one control word per step
    function automatic t_ctrl ucode_rom(input t_pc pc);
        t_ctrl w;
        w = '{in_rdy: 1'b0, upd: 1'b0, div_init: 1'b0, div_step: 1'b0,
              div_fin: 1'b0, emit: 1'b0, cond: COND_ALWAYS, target: PC_FETCH};
        case (pc)
            PC_FETCH: begin
                w.in_rdy = 1'b1;
                w.cond   = COND_NO_IN;
                w.target = PC_FETCH;
            end
            PC_UPDATE: begin
                w.upd    = 1'b1;
                w.cond   = COND_NOT_FINAL;
                w.target = PC_EMIT;
            end
            PC_DIV_INIT: begin
                w.div_init = 1'b1;
                w.cond     = COND_NONE;
            end
            PC_DIV_STEP: begin
                w.div_step = 1'b1;
                w.cond     = COND_DIV_MORE;
                w.target   = PC_DIV_STEP;
            end
            PC_DIV_FIN: begin
                w.div_fin = 1'b1;
                w.cond    = COND_NONE;
            end
            PC_EMIT: begin
                w.emit   = 1'b1;
                w.cond   = COND_OUT_BUSY;
                w.target = PC_EMIT;
            end
            PC_RETURN: begin
                w.cond   = COND_ALWAYS;
                w.target = PC_FETCH;
            end
            default: begin
                w.cond   = COND_ALWAYS;
                w.target = PC_FETCH;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== sv/lcar_chan_if.sv =====
// Valid/ready channel interface carrying one word of a given type.
interface lcar_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/load_cell_adc_reader.sv =====
// Load cell converter serial readout with a microcoded sequencer and a serial divider.
//
// Channels: i_in_ch takes one word per time tick (start_request, data_pin);
// o_res_ch gives one result word per tick (clock_pin, busy_res, done_res,
// raw_code, weight); i_cfg_ch writes tare_offset (0), scale_divisor (1)
// and half_period_ticks (2), and is always ready.
// A short program steps through fetch, update, emit and return for an
// ordinary tick, and the result is loaded into the output register at the
// emit step. On the tick that ends a readout the program also runs the
// restoring divider between update and emit: one set-up step, then one
// quotient bit per cycle for DATA_BITS + FRACTION_BITS bits, then one
// saturation step.
// The next word is accepted as soon as the program is back at fetch, even
// while the previous result still waits in the output register.
// When the receiver stalls, the program holds at the emit step and no new
// word is taken until the pending result has left.
// Reset clears the readout state, the held code and weight, and loads the
// registers with tare 100, divisor 1000 and half period 1.
`include "assert_macros.svh"

module load_cell_adc_reader #(
    parameter int DATA_BITS     = 24,
    parameter int FRACTION_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lcar_chan_if.sink   i_in_ch,
    lcar_chan_if.source o_res_ch,
    lcar_chan_if.sink   i_cfg_ch
);

    localparam int QW = DATA_BITS + FRACTION_BITS;
    localparam int PW = $clog2(DATA_BITS + 1);
    localparam int CW = $clog2(QW + 1);
    localparam int MW = (DATA_BITS > lcar_pkg::TARE_W) ? DATA_BITS : lcar_pkg::TARE_W;
    localparam int DW = lcar_pkg::DIVIS_W;

    // Configuration registers
    logic [lcar_pkg::TARE_W-1:0]  r_tare;
    logic [lcar_pkg::DIVIS_W-1:0] r_divisor;
    logic [lcar_pkg::HALF_W-1:0]  r_half;

    // Sequencer
    lcar_pkg::t_pc   r_pc, n_pc;
    lcar_pkg::t_ctrl ctrl;
    logic            take_jump;

    // Latched input word
    logic r_start, r_din;

    // Readout state
    logic [PW-1:0]                 r_pulse, n_pulse;
    logic [lcar_pkg::HALF_W-1:0]   r_tick, n_tick;
    logic                          r_clk_lvl, n_clk_lvl;
    logic                          r_busy, n_busy;
    logic                          r_done, n_done;
    logic [DATA_BITS-1:0]          r_shift, n_shift;
    logic [DATA_BITS-1:0]          r_code, n_code;
    logic [lcar_pkg::WEIGHT_W-1:0] r_weight;

    // Divider
    logic [QW-1:0] r_dq;
    logic [DW-1:0] r_rem;
    logic [CW-1:0] r_div_cnt;
    logic          r_zero, r_sat;
    logic [DW:0]   trial;
    logic          trial_ge;
    logic [MW-1:0] diff;

    // Output register
    lcar_pkg::t_res_word r_out;
    logic                r_out_vld;
    logic                out_busy;

    logic [lcar_pkg::HALF_W-1:0] hold;
    logic                        tick_done;
    logic                        final_w;

    assign ctrl = lcar_pkg::ucode_rom(r_pc);

    // Handshakes
    assign i_in_ch.ready  = ctrl.in_rdy;
    assign i_cfg_ch.ready = 1'b1;
    assign o_res_ch.valid   = r_out_vld;
    assign o_res_ch.payload = r_out;
    assign out_busy = r_out_vld && !o_res_ch.ready;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tare    <= lcar_pkg::TARE_RST;
            r_divisor <= lcar_pkg::DIVIS_RST;
            r_half    <= lcar_pkg::HALF_RST;
        end else if (i_cfg_ch.valid) begin
            case (i_cfg_ch.payload.reg_index)
                lcar_pkg::CFG_TARE:    r_tare    <= i_cfg_ch.payload.wr_data;
                lcar_pkg::CFG_DIVISOR: r_divisor <= i_cfg_ch.payload.wr_data;
                lcar_pkg::CFG_HALF:
                    r_half <= i_cfg_ch.payload.wr_data[lcar_pkg::HALF_W-1:0];
                default: ;
            endcase
        end
    end

    // Decode the level timing and the last falling edge
    assign hold      = (r_half == '0) ? lcar_pkg::HALF_W'(1) : r_half;
    assign tick_done = (r_tick >= hold);
    assign final_w   = r_busy && tick_done && r_clk_lvl && (r_pulse == PW'(DATA_BITS));

    // Select the jump condition
    always_comb begin
        case (ctrl.cond)
            lcar_pkg::COND_NONE:      take_jump = 1'b0;
            lcar_pkg::COND_ALWAYS:    take_jump = 1'b1;
            lcar_pkg::COND_NO_IN:     take_jump = !i_in_ch.valid;
            lcar_pkg::COND_NOT_FINAL: take_jump = !final_w;
            lcar_pkg::COND_DIV_MORE:  take_jump = (r_div_cnt > CW'(1));
            lcar_pkg::COND_OUT_BUSY:  take_jump = out_busy;
            default:                  take_jump = 1'b0;
        endcase
    end

    // Advance the step counter
    always_comb begin
        n_pc = take_jump ? ctrl.target : lcar_pkg::t_pc'(r_pc + 3'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= lcar_pkg::PC_FETCH;
        end else begin
            r_pc <= n_pc;
        end
    end

    // Latch the accepted word
    always_ff @(posedge i_clk) begin
        if (i_in_ch.valid && ctrl.in_rdy) begin
            r_start <= i_in_ch.payload.start_request;
            r_din   <= i_in_ch.payload.data_pin;
        end
    end

    // Compute the tick update of the readout state
    always_comb begin
        n_pulse   = r_pulse;
        n_tick    = r_tick;
        n_clk_lvl = r_clk_lvl;
        n_busy    = r_busy;
        n_shift   = r_shift;
        n_code    = r_code;
        n_done    = 1'b0;
        if (!r_busy) begin
            if (r_start) begin
                n_busy    = 1'b1;
                n_clk_lvl = 1'b0;
                n_pulse   = '0;
                n_tick    = lcar_pkg::HALF_W'(1);
                n_shift   = '0;
            end
        end else if (!tick_done) begin
            n_tick = r_tick + lcar_pkg::HALF_W'(1);
        end else begin
            n_tick = lcar_pkg::HALF_W'(1);
            if (!r_clk_lvl) begin
                n_clk_lvl = 1'b1;
            end else begin
                n_clk_lvl = 1'b0;
                if (r_pulse < PW'(DATA_BITS)) begin
                    n_shift = {r_shift[DATA_BITS-2:0], r_din};
                    n_pulse = r_pulse + PW'(1);
                end else begin
                    n_code  = r_shift ^ (DATA_BITS'(1) << (DATA_BITS - 1));
                    n_busy  = 1'b0;
                    n_pulse = '0;
                    n_tick  = '0;
                    n_done  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse   <= '0;
            r_tick    <= '0;
            r_clk_lvl <= 1'b0;
            r_busy    <= 1'b0;
            r_done    <= 1'b0;
            r_shift   <= '0;
            r_code    <= '0;
        end else if (ctrl.upd) begin
            r_pulse   <= n_pulse;
            r_tick    <= n_tick;
            r_clk_lvl <= n_clk_lvl;
            r_busy    <= n_busy;
            r_done    <= n_done;
            r_shift   <= n_shift;
            r_code    <= n_code;
        end
    end

    // Restoring divider: one quotient bit per step
    assign diff     = MW'(r_code) - MW'(r_tare);
    assign trial    = {r_rem, r_dq[QW-1]};
    assign trial_ge = (trial >= {1'b0, r_divisor});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (ctrl.div_init) begin
            r_div_cnt <= CW'(QW);
        end else if (ctrl.div_step) begin
            r_div_cnt <= r_div_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.div_init) begin
            r_dq   <= QW'(diff[DATA_BITS-1:0]) << FRACTION_BITS;
            r_rem  <= '0;
            r_zero <= !(MW'(r_code) > MW'(r_tare));
            r_sat  <= (r_divisor == '0);
        end else if (ctrl.div_step) begin
            r_rem <= trial_ge ? DW'(trial - {1'b0, r_divisor}) : DW'(trial);
            r_dq  <= {r_dq[QW-2:0], trial_ge};
        end
    end

    // Saturate and hold the weight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= '0;
        end else if (ctrl.div_fin) begin
            if (r_zero) begin
                r_weight <= '0;
            end else if (r_sat || ((r_dq >> lcar_pkg::WEIGHT_W) != '0)) begin
                r_weight <= '1;
            end else begin
                r_weight <= lcar_pkg::WEIGHT_W'(r_dq);
            end
        end
    end

    // Load the result word, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (ctrl.emit && !out_busy) begin
            r_out_vld <= 1'b1;
        end else if (o_res_ch.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.emit && !out_busy) begin
            r_out.clock_pin <= r_clk_lvl;
            r_out.busy_res  <= r_busy;
            r_out.done_res  <= r_done;
            r_out.raw_code  <= lcar_pkg::RAW_W'(r_code);
            r_out.weight    <= r_weight;
        end
    end

    // Checks on the sequencer and datapath
    `LCAR_ASSERT(a_accept_then_update, i_clk, i_rst_n, (i_in_ch.valid && i_in_ch.ready) |=> (r_pc == lcar_pkg::PC_UPDATE), "accepted word not followed by update step")
    `LCAR_ASSERT(a_done_not_busy, i_clk, i_rst_n, (r_out_vld && r_out.done_res) |-> !r_out.busy_res, "done result still reports busy")
    `LCAR_ASSERT(a_div_count_live, i_clk, i_rst_n, ctrl.div_step |-> (r_div_cnt != '0), "divider step with exhausted count")
    `LCAR_ASSERT(a_pulse_range, i_clk, i_rst_n, r_pulse <= PW'(DATA_BITS), "pulse index beyond data bits")

endmodule
